// File: rtl/pmdm_pkg.sv
// Package for the PCM mean-level decibel meter.
// Holds the shared widths, constants and control structs; no dependencies.
package pmdm_pkg;

  // Fixed widths of the sample path.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 17;
  localparam int LEVEL_W  = 8;

  // Limb width of the multiword numbers and of the shared multiplier.
  localparam int LIMB_W = 32;

  // The level is 20*log10, so both operands are raised to the 20th power.
  localparam int POW_N  = 20;
  localparam int PASS_W = 5;

  // Each dB step multiplies by ten.
  localparam int TEN = 10;

  // Upper bound on the level magnitude.
  localparam int LEVEL_LIMIT = 127;
  localparam int K_W         = 7;

  // Request from the front end to the level converter.
  typedef struct packed {
    logic start;  // begin a conversion with the latched operands
    logic take;   // the finished level moves to the output register
    logic neg;    // the mean is below one, so the level is negative
    logic zero;   // the sum is zero, so the level is zero
  } conv_ctl_t;

  // Status of the level converter.
  typedef struct packed {
    logic busy;   // a conversion is running or its result waits
    logic done;   // the level is ready
  } conv_sts_t;

endpackage

// File: rtl/pcm_mean_level_decibel_meter.sv
// Top level of the PCM mean-level decibel meter: accumulator, handshakes, output register.
// Depends on pmdm_pkg and pmdm_level_conv (which uses pmdm_limb_mac).

// The meter takes one signed 16-bit sample per item and adds its magnitude to a
// running sum, -32768 counting as 32768, while it counts the samples; once the
// count reaches MAX_SAMPLES further samples are ignored. An item that carries
// last_i closes the buffer and yields one result item, the level
// 20*log10(sum/count) truncated toward zero, or 0 when the sum is zero. The
// level is exact: a sequencer drives one shared limb multiply-add unit over
// multiword numbers of NL 32-bit limbs, where NL = ceil((20*SUM_W+4)/32) and
// SUM_W is the sum width (32 bits, NL = 21, at the default MAX_SAMPLES). While
// no conversion runs, items without last_i are accepted without a stall. An
// item with last_i holds off the input while both operands are raised to the
// 20th power, then for one multiply-by-ten pass and one compare scan per dB of
// level magnitude, and until the level has moved to the output register; a
// zero sum skips the passes. The result sits in an output register, so
// accumulation of the next buffer can start while it waits.
module pcm_mean_level_decibel_meter #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pmdm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pmdm_pkg::LEVEL_W-1:0]  level_db_o
);

  localparam longint unsigned SUM_MAX = 64'd32768 * 64'(MAX_SAMPLES);
  localparam int SUM_W = $clog2(SUM_MAX + 64'd1);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int MW    = pmdm_pkg::MAG_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [SUM_W-1:0] sum_q, sum_d, sum_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic             out_valid_q, out_valid_d;
  logic signed [pmdm_pkg::LEVEL_W-1:0] level_q, level_d;

  logic             in_accept;
  logic             room;
  logic [MW-1:0]    mag;
  logic [SUM_W-1:0] cnt_ext;
  logic             mean_low;
  logic [SUM_W-1:0] conv_hi;
  logic [SUM_W-1:0] conv_lo;
  logic signed [pmdm_pkg::LEVEL_W-1:0] conv_level;

  pmdm_pkg::conv_ctl_t conv_ctl;
  pmdm_pkg::conv_sts_t conv_sts;

  // The input is held off for the whole conversion and until its result has
  // moved into the output register.
  assign in_stall_o = conv_sts.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Magnitude of the sample; the most negative code maps to 32768.
  assign mag = sample_i[pmdm_pkg::SAMPLE_W-1] ? (MW'(~sample_i) + MW'(1))
                                              : MW'(sample_i);

  // Samples past MAX_SAMPLES are neither summed nor counted.
  assign room  = (cnt_q < CNT_MAX);
  assign sum_n = room ? (sum_q + SUM_W'(mag)) : sum_q;
  assign cnt_n = room ? (cnt_q + CNT_W'(1)) : cnt_q;

  // The converter works on the larger over the smaller operand and the sign
  // is applied at the end.
  assign cnt_ext  = SUM_W'(cnt_n);
  assign mean_low = (sum_n < cnt_ext);
  assign conv_hi  = mean_low ? cnt_ext : sum_n;
  assign conv_lo  = mean_low ? sum_n : cnt_ext;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (in_accept) begin
      if (last_i) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_n;
        cnt_d = cnt_n;
      end
    end
  end

  // The finished level moves over when the output register is free or drains.
  assign conv_ctl.start = in_accept && last_i;
  assign conv_ctl.take  = conv_sts.done && (!out_valid_q || !out_stall_i);
  assign conv_ctl.neg   = mean_low;
  assign conv_ctl.zero  = (sum_n == '0);

  pmdm_level_conv #(
    .SUM_W(SUM_W)
  ) u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (conv_ctl),
    .hi_i   (conv_hi),
    .lo_i   (conv_lo),
    .sts_o  (conv_sts),
    .level_o(conv_level)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    if (conv_ctl.take) begin
      out_valid_d = 1'b1;
      level_d     = conv_level;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_db_o  = level_q;

  // A closing sample starts a conversion, so the input must stall next cycle.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_i) |=> in_stall_o)
    else $error("input not stalled after a closing sample");

  // A closing sample leaves the accumulator empty.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_i) |=> ((sum_q == '0) && (cnt_q == '0)))
    else $error("accumulator not cleared after a closing sample");

  // The sample count never passes its limit.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("sample count beyond its limit");

  // A new result only appears out of a finished conversion.
  a_out_from_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(conv_sts.done))
    else $error("result item without a finished conversion");

endmodule

// File: rtl/pmdm_limb_mac.sv
// Shared multiply-add unit of the meter: one limb times a scalar plus a carry.
// Depends on nothing but its parameters.
module pmdm_limb_mac #(
  parameter int XW = 32,
  parameter int SW = 32
) (
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] s_i,
  input  logic [SW-1:0] c_i,
  output logic [XW-1:0] lo_o,
  output logic [SW-1:0] hi_o
);

  localparam int PW = XW + SW;

  logic [PW-1:0] prod;

  // The sum never exceeds PW bits since the carry is below the scalar's range.
  assign prod = (PW'(x_i) * PW'(s_i)) + PW'(c_i);
  assign lo_o = prod[XW-1:0];
  assign hi_o = prod[PW-1:XW];

endmodule

// File: rtl/pmdm_level_conv.sv
// Level converter: finds the largest k, at most 127, with 10^k * lo^20 <= hi^20 exactly.
// Uses pmdm_pkg and one shared pmdm_limb_mac over multiword limb arrays.
module pmdm_level_conv #(
  parameter int SUM_W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmdm_pkg::conv_ctl_t             ctl_i,
  input  logic [SUM_W-1:0]                hi_i,
  input  logic [SUM_W-1:0]                lo_i,
  output pmdm_pkg::conv_sts_t             sts_o,
  output logic signed [pmdm_pkg::LEVEL_W-1:0] level_o
);

  localparam int LW     = pmdm_pkg::LIMB_W;
  localparam int PROD_W = pmdm_pkg::POW_N * SUM_W + 4;
  localparam int NL     = (PROD_W + LW - 1) / LW;
  localparam int IDX_W  = (NL > 1) ? $clog2(NL) : 1;
  localparam int KW     = pmdm_pkg::K_W;
  localparam int PW     = pmdm_pkg::PASS_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NL - 1);
  localparam logic [PW-1:0]    LAST_PASS = PW'(pmdm_pkg::POW_N - 1);
  localparam logic [KW-1:0]    LAST_K    = KW'(pmdm_pkg::LEVEL_LIMIT - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POWT = 3'd1;
  localparam logic [2:0] ST_POWA = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]       state_q;
  logic [IDX_W-1:0] idx_q;
  logic [PW-1:0]    pass_q;
  logic [KW-1:0]    k_q;
  logic             ptr_q;
  logic             neg_q;
  logic [SUM_W-1:0] carry_q;
  logic [SUM_W-1:0] hi_q;
  logic [SUM_W-1:0] lo_q;

  logic [LW-1:0] top_q  [NL];
  logic [LW-1:0] buf0_q [NL];
  logic [LW-1:0] buf1_q [NL];

  logic [LW-1:0]    top_rd;
  logic [LW-1:0]    b0_rd;
  logic [LW-1:0]    b1_rd;
  logic [LW-1:0]    acc_rd;
  logic [LW-1:0]    nxt_rd;
  logic [LW-1:0]    one_limb;
  logic [LW-1:0]    mac_x;
  logic [SUM_W-1:0] mac_s;
  logic [LW-1:0]    mac_lo;
  logic [SUM_W-1:0] mac_hi;

  assign top_rd = top_q[idx_q];
  assign b0_rd  = buf0_q[idx_q];
  assign b1_rd  = buf1_q[idx_q];
  assign acc_rd = ptr_q ? b1_rd : b0_rd;
  assign nxt_rd = ptr_q ? b0_rd : b1_rd;

  // The first power pass multiplies the constant one, so no array clear is needed.
  assign one_limb = (idx_q == '0) ? LW'(1) : '0;

  always_comb begin
    mac_x = '0;
    mac_s = '0;
    case (state_q)
      ST_POWT: begin
        mac_x = (pass_q == '0) ? one_limb : top_rd;
        mac_s = hi_q;
      end
      ST_POWA: begin
        mac_x = (pass_q == '0) ? one_limb : b0_rd;
        mac_s = lo_q;
      end
      ST_MUL: begin
        mac_x = acc_rd;
        mac_s = SUM_W'(pmdm_pkg::TEN);
      end
      default: begin
        mac_x = '0;
        mac_s = '0;
      end
    endcase
  end

  pmdm_limb_mac #(
    .XW(LW),
    .SW(SUM_W)
  ) u_mac (
    .x_i (mac_x),
    .s_i (mac_s),
    .c_i (carry_q),
    .lo_o(mac_lo),
    .hi_o(mac_hi)
  );

  // Limb arrays, written one limb per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_POWT: top_q[idx_q] <= mac_lo;
      ST_POWA: buf0_q[idx_q] <= mac_lo;
      ST_MUL: begin
        if (ptr_q) begin
          buf0_q[idx_q] <= mac_lo;
        end else begin
          buf1_q[idx_q] <= mac_lo;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pass_q  <= '0;
      k_q     <= '0;
      ptr_q   <= 1'b0;
      neg_q   <= 1'b0;
      carry_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) begin
            hi_q    <= hi_i;
            lo_q    <= lo_i;
            neg_q   <= ctl_i.neg;
            k_q     <= '0;
            ptr_q   <= 1'b0;
            idx_q   <= '0;
            pass_q  <= '0;
            carry_q <= '0;
            state_q <= ctl_i.zero ? ST_DONE : ST_POWT;
          end
        end
        ST_POWT, ST_POWA: begin
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            carry_q <= '0;
            if (pass_q == LAST_PASS) begin
              pass_q  <= '0;
              state_q <= (state_q == ST_POWT) ? ST_POWA : ST_MUL;
            end else begin
              pass_q <= pass_q + PW'(1);
            end
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            carry_q <= mac_hi;
          end
        end
        ST_MUL: begin
          if (idx_q == LAST_IDX) begin
            carry_q <= '0;
            state_q <= ST_CMP;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            carry_q <= mac_hi;
          end
        end
        ST_CMP: begin
          // Scan from the top limb; the first differing limb decides.
          if (nxt_rd > top_rd) begin
            state_q <= ST_DONE;
          end else if ((nxt_rd < top_rd) || (idx_q == '0)) begin
            ptr_q <= ~ptr_q;
            k_q   <= k_q + KW'(1);
            idx_q <= '0;
            if (k_q == LAST_K) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_MUL;
            end
          end else begin
            idx_q <= idx_q - IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (ctl_i.take) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);

  assign level_o = neg_q ? (pmdm_pkg::LEVEL_W'(0) - pmdm_pkg::LEVEL_W'(k_q))
                         : pmdm_pkg::LEVEL_W'(k_q);

endmodule

// File: verif/pmdm_level_checker.sv
// Checker for the PCM mean-level decibel meter: it watches both channels,
// predicts each level from the accepted samples and compares it with the result.
// Depends on pmdm_pkg for the sample and level widths and the level constants.
module pmdm_level_checker #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [pmdm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [pmdm_pkg::LEVEL_W-1:0]  level_db_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   samples_seen_o,
  output int                                   levels_checked_o
);

  // Shadow copy of the accumulator.
  logic [63:0] mag_sum;
  logic [31:0] sample_cnt;

  logic signed [pmdm_pkg::LEVEL_W-1:0] level_q[$];

  // Exact truncated 20*log10(sum/cnt): the largest k with 10^k * lo^20 <= hi^20,
  // negated when the mean is below one.
  function automatic logic signed [pmdm_pkg::LEVEL_W-1:0] mean_level_db(
    input logic [63:0] sum,
    input logic [31:0] cnt
  );
    logic [767:0] hi_pow;
    logic [767:0] lo_pow;
    logic [63:0]  hi;
    logic [63:0]  lo;
    int           k;
    if (sum == 0 || cnt == 0) return '0;
    hi = (sum >= 64'(cnt)) ? sum : 64'(cnt);
    lo = (sum >= 64'(cnt)) ? 64'(cnt) : sum;
    hi_pow = 768'd1;
    lo_pow = 768'd1;
    for (int i = 0; i < pmdm_pkg::POW_N; i++) begin
      hi_pow = hi_pow * hi;
      lo_pow = lo_pow * lo;
    end
    k = 0;
    while (k < pmdm_pkg::LEVEL_LIMIT && lo_pow * pmdm_pkg::TEN <= hi_pow) begin
      lo_pow = lo_pow * pmdm_pkg::TEN;
      k++;
    end
    return (sum >= 64'(cnt)) ? pmdm_pkg::LEVEL_W'(k) : pmdm_pkg::LEVEL_W'(-k);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [pmdm_pkg::LEVEL_W-1:0] want;
    logic [pmdm_pkg::MAG_W-1:0]          mag;
    if (!rst_ni) begin
      mag_sum          <= '0;
      sample_cnt       <= '0;
      level_q.delete();
      fail_count_o     <= 0;
      pending_o        <= 0;
      samples_seen_o   <= 0;
      levels_checked_o <= 0;
    end else begin
      // The result side goes first: a result leaving now can only belong to
      // an older buffer, never to the item accepted at this same edge.
      if (out_valid_i && !out_stall_i) begin
        if (level_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: level %0d dB arrived with none outstanding", $time, level_db_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = level_q.pop_front();
          if (level_db_i !== want) begin
            if (fail_count_o < 10)
              $display("%0t: level mismatch, expected %0d dB, got %0d dB",
                       $time, want, level_db_i);
            fail_count_o <= fail_count_o + 1;
          end
          levels_checked_o <= levels_checked_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        mag = sample_i[pmdm_pkg::SAMPLE_W-1]
            ? (pmdm_pkg::MAG_W'(1) << (pmdm_pkg::SAMPLE_W)) - {1'b0, sample_i}
            : {1'b0, sample_i};
        samples_seen_o <= samples_seen_o + 1;
        if (last_i) begin
          if (sample_cnt < MAX_SAMPLES) level_q.push_back(mean_level_db(mag_sum + mag,
                                                                        sample_cnt + 1));
          else level_q.push_back(mean_level_db(mag_sum, sample_cnt));
          mag_sum    <= '0;
          sample_cnt <= '0;
        end else if (sample_cnt < MAX_SAMPLES) begin
          mag_sum    <= mag_sum + mag;
          sample_cnt <= sample_cnt + 1;
        end
      end
      pending_o <= level_q.size();
    end
  end

endmodule

// File: verif/pcm_mean_level_decibel_meter_tb.sv
// Testbench top for the PCM mean-level decibel meter: clock, reset, sample
// stimulus, result-side stalls, watchdog and verdict.
// Depends on pmdm_pkg, the meter RTL and pmdm_level_checker.
module pcm_mean_level_decibel_meter_tb;

  localparam int MAX_SAMPLES = 65536;

  // A last item can hold the input off while the level is worked out; the
  // watchdog limit is set well above that time.
  localparam int QUIET_LIMIT = 40000;

  // Amplitude classes used to shape random buffers so the levels spread
  // from deep negative values up to full scale.
  typedef enum int {AMP_ZERO, AMP_TINY, AMP_MID, AMP_FULL, AMP_EDGE} amp_kind_e;

  logic                                 clk_i;
  logic                                 rst_ni       = 1'b0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_stall_o;
  logic signed [pmdm_pkg::SAMPLE_W-1:0] sample_i     = '0;
  logic                                 last_i       = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i  = 1'b0;
  logic signed [pmdm_pkg::LEVEL_W-1:0]  level_db_o;

  int fail_count;
  int pending;
  int samples_seen;
  int levels_checked;

  // Idle percentages of the two sides, changed from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  pcm_mean_level_decibel_meter #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_db_o  (level_db_o)
  );

  pmdm_level_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_i         (sample_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .level_db_i       (level_db_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .samples_seen_o   (samples_seen),
    .levels_checked_o (levels_checked)
  );

  // The result side stalls at random, one fresh decision per cycle. The
  // decision never looks at out_valid_o, so stalls land on every phase of a
  // conversion as well as on waiting results.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample item and returns at the edge that accepts it. The
  // sender may first idle for a few cycles; valid is lowered only in those
  // idle steps, so a valid that stays high is never dropped and raised again
  // within one time step.
  task automatic send_sample(input logic signed [pmdm_pkg::SAMPLE_W-1:0] value,
                             input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    last_i     <= closes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Holds the sender off until every expected level has come back. The first
  // edge lets the checker book the item accepted just before.
  task automatic drain_levels();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [pmdm_pkg::SAMPLE_W-1:0] pick_sample(
    input amp_kind_e kind
  );
    case (kind)
      AMP_ZERO: return '0;
      AMP_TINY: return pmdm_pkg::SAMPLE_W'($urandom_range(6)) - pmdm_pkg::SAMPLE_W'(3);
      AMP_MID:  return pmdm_pkg::SAMPLE_W'($urandom_range(600)) - pmdm_pkg::SAMPLE_W'(300);
      AMP_FULL: return pmdm_pkg::SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(2))
          0:       return {1'b1, {(pmdm_pkg::SAMPLE_W-1){1'b0}}};
          1:       return {1'b0, {(pmdm_pkg::SAMPLE_W-1){1'b1}}};
          default: return pmdm_pkg::SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Random buffers until about n_items samples have gone in. Most buffers are
  // short so conversions come often; now and then a longer one pushes the
  // count and the sum up. Each buffer has a main amplitude class, with a
  // sprinkling of samples from other classes, and every buffer is closed by a
  // last item so nothing is left half accumulated.
  task automatic random_buffers(input int n_items);
    int        sent;
    int        len;
    amp_kind_e kind;
    amp_kind_e this_kind;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(19) == 0) ? $urandom_range(400, 60) : $urandom_range(24, 1);
      kind = amp_kind_e'($urandom_range(4));
      for (int i = 0; i < len; i++) begin
        this_kind = ($urandom_range(9) == 0) ? amp_kind_e'($urandom_range(4)) : kind;
        send_sample(pick_sample(this_kind), i == len - 1);
      end
      sent += len;
      // Occasionally let every pending level come out before going on.
      if ($urandom_range(15) == 0) drain_levels();
    end
  endtask

  initial begin
    // Reset is held low from time zero and released at a clock edge.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: the sender idles a little, the receiver a lot.
    send_idle_pct  = 13;
    recv_stall_pct = 73;

    // Directed buffers. An all-zero buffer gives 0 dB; a single most negative
    // sample counts as 32768 and gives the top level; a mean of exactly one
    // gives 0 dB from both signs; means below one give negative levels
    // truncated toward zero; alternating bit patterns toggle every sample bit.
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd10, 1'b1);
    send_sample(-16'sd100, 1'b1);
    send_sample(16'sd1000, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sd21846, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    drain_levels();

    random_buffers(330);
    drain_levels();

    // Phase two: the roles swap.
    send_idle_pct  = 73;
    recv_stall_pct = 13;
    random_buffers(330);
    drain_levels();

    // Phase three: both sides run flat out.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_buffers(340);

    // A short buffer at the end shows the state cleared.
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd0, 1'b1);

    drain_levels();
    repeat (200) @(posedge clk_i);

    $display("Checked %0d levels from %0d samples over three idling phases.",
             levels_checked, samples_seen);
    $display("Covered full-scale, zero and sub-unity means in short and long buffers.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d levels never arrived", fail_count, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pmdm_pkg.sv
rtl/pmdm_limb_mac.sv
rtl/pmdm_level_conv.sv
rtl/pcm_mean_level_decibel_meter.sv
verif/pmdm_level_checker.sv
verif/pcm_mean_level_decibel_meter_tb.sv
